@@ design/rotary_encoder_bounded_counter_defines.svh @@
// Assertion macros for the top-level design file.
`ifndef ROTARY_ENCODER_BOUNDED_COUNTER_DEFINES_SVH
`define ROTARY_ENCODER_BOUNDED_COUNTER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define RECO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define RECO_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ design/reco_pkg.sv @@
package reco_pkg;

    // Operation carried with each input transaction
    typedef enum logic [1:0] {
        FUNC_SAMPLE      = 2'd0,
        FUNC_LOAD        = 2'd1,
        FUNC_CLAMP       = 2'd2,
        FUNC_LOAD_OR_MIN = 2'd3
    } func_t;

    // Detent step report
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_t;

    // Pin pair levels: bit1 clock pin, bit0 data pin
    localparam logic [1:0] PINS_LOW  = 2'b00;
    localparam logic [1:0] PINS_DATA = 2'b01;
    localparam logic [1:0] PINS_CLK  = 2'b10;
    localparam logic [1:0] PINS_HIGH = 2'b11;

    // Register index (paddr[3:2])
    localparam logic [1:0] REG_MIN_VALUE = 2'd0;
    localparam logic [1:0] REG_MAX_VALUE = 2'd1;
    localparam logic [1:0] REG_WRAP_MODE = 2'd2;

    localparam int LIMIT_WIDTH = 16;
    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;

    // Decoder result handed to the counter
    typedef struct packed {
        logic  move;
        logic  up;
        step_t step;
    } decode_t;

endpackage

@@ design/reco_decoder.sv @@
module reco_decoder
    import reco_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_en,
    input  logic [1:0] pin_pair,
    output decode_t    decode
);

    logic [1:0] last_pair_reg;
    logic [1:0] last_pair_next;
    logic       rest_high_reg;
    logic       rest_high_next;

    // Detent detection against the last seen pair and the last rest level
    always_comb
    begin
        decode.move = 1'b0;
        decode.up   = 1'b0;
        decode.step = STEP_NONE;
        if (pin_pair != last_pair_reg)
        begin
            case (pin_pair)
                PINS_CLK:
                begin
                    decode.move = 1'b1;
                    decode.up   = rest_high_reg;
                    decode.step = rest_high_reg ? STEP_UP : STEP_DOWN;
                end
                PINS_DATA:
                begin
                    decode.move = 1'b1;
                    decode.up   = !rest_high_reg;
                    decode.step = rest_high_reg ? STEP_DOWN : STEP_UP;
                end
                default:
                begin
                    decode.move = 1'b0;
                end
            endcase
        end
    end

    // Pin history update
    always_comb
    begin
        last_pair_next = last_pair_reg;
        rest_high_next = rest_high_reg;
        if (sample_en)
        begin
            last_pair_next = pin_pair;
            case (pin_pair)
                PINS_LOW:  rest_high_next = 1'b0;
                PINS_HIGH: rest_high_next = 1'b1;
                default:   rest_high_next = rest_high_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pair_reg <= PINS_LOW;
            rest_high_reg <= 1'b0;
        end
        else
        begin
            last_pair_reg <= last_pair_next;
            rest_high_reg <= rest_high_next;
        end
    end

endmodule

@@ design/reco_counter.sv @@
module reco_counter
    import reco_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   op_en,
    input  func_t                  func,
    input  decode_t                decode,
    input  logic [LIMIT_WIDTH-1:0] load_value,
    input  logic [LIMIT_WIDTH-1:0] min_value,
    input  logic [LIMIT_WIDTH-1:0] max_value,
    input  logic                   wrap_mode,
    output logic [LIMIT_WIDTH-1:0] count,
    output logic                   load_taken
);

    // Compare width holds both the counter and the limits plus a sign bit
    localparam int XW = ((COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH) + 1;

    logic [COUNT_WIDTH-1:0] counter_reg;
    logic [COUNT_WIDTH-1:0] counter_next;
    logic [COUNT_WIDTH-1:0] op_result;
    logic [COUNT_WIDTH-1:0] clamp_hi;
    logic [COUNT_WIDTH-1:0] min_fit;
    logic [COUNT_WIDTH-1:0] max_fit;
    logic [COUNT_WIDTH-1:0] load_fit;
    logic signed [XW-1:0]   cnt_x;
    logic signed [XW-1:0]   hi_x;
    logic signed [XW-1:0]   min_x;
    logic signed [XW-1:0]   max_x;
    logic signed [XW-1:0]   load_x;
    logic signed [XW-1:0]   next_x;
    logic                   load_in_range;
    logic                   limits_ok;
    logic                   taken;

    // Sign-extended operands and limits cut to counter width
    assign cnt_x  = $signed({{(XW-COUNT_WIDTH){counter_reg[COUNT_WIDTH-1]}}, counter_reg});
    assign min_x  = $signed({{(XW-LIMIT_WIDTH){min_value[LIMIT_WIDTH-1]}}, min_value});
    assign max_x  = $signed({{(XW-LIMIT_WIDTH){max_value[LIMIT_WIDTH-1]}}, max_value});
    assign load_x = $signed({{(XW-LIMIT_WIDTH){load_value[LIMIT_WIDTH-1]}}, load_value});
    assign min_fit  = min_x[COUNT_WIDTH-1:0];
    assign max_fit  = max_x[COUNT_WIDTH-1:0];
    assign load_fit = load_x[COUNT_WIDTH-1:0];

    assign load_in_range = (load_x > min_x) && (load_x < max_x);
    assign limits_ok     = (min_x < max_x);

    // Clamp runs the upper check first, then tests the result against the minimum
    assign clamp_hi = (cnt_x > max_x) ? max_fit : counter_reg;
    assign hi_x     = $signed({{(XW-COUNT_WIDTH){clamp_hi[COUNT_WIDTH-1]}}, clamp_hi});

    // Operation select
    always_comb
    begin
        op_result = counter_reg;
        taken     = 1'b0;
        case (func)
            FUNC_SAMPLE:
            begin
                if (decode.move)
                begin
                    if (decode.up)
                    begin
                        if (cnt_x < max_x)
                            op_result = counter_reg + COUNT_WIDTH'(1);
                        else if (wrap_mode)
                            op_result = min_fit;
                    end
                    else
                    begin
                        if (cnt_x > min_x)
                            op_result = counter_reg - COUNT_WIDTH'(1);
                        else if (wrap_mode)
                            op_result = max_fit;
                    end
                end
            end
            FUNC_LOAD:
            begin
                if (load_in_range)
                begin
                    op_result = load_fit;
                    taken     = 1'b1;
                end
            end
            FUNC_CLAMP:
            begin
                if (limits_ok)
                    op_result = (hi_x < min_x) ? min_fit : clamp_hi;
            end
            FUNC_LOAD_OR_MIN:
            begin
                if (limits_ok)
                begin
                    if (load_in_range)
                    begin
                        op_result = load_fit;
                        taken     = 1'b1;
                    end
                    else
                    begin
                        op_result = min_fit;
                    end
                end
            end
            default:
            begin
                op_result = counter_reg;
            end
        endcase
    end

    assign counter_next = op_en ? op_result : counter_reg;
    assign next_x = $signed({{(XW-COUNT_WIDTH){op_result[COUNT_WIDTH-1]}}, op_result});
    assign count      = next_x[LIMIT_WIDTH-1:0];
    assign load_taken = taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            counter_reg <= '0;
        else
            counter_reg <= counter_next;
    end

endmodule

@@ design/rotary_encoder_bounded_counter.sv @@
// Rotary encoder decoder with a bounded up/down counter. Each input transaction carries
// an operation in s_tuser (sample pins, load, clamp, load or minimum) and produces
// exactly one result transaction with the new count, the detected step and whether the
// load value was taken. The block takes one transaction per cycle unless m_tready stalls
// the output: an input register feeds the decode and counter logic, which updates the
// counter and fills the output register, so m_tvalid rises once a transaction has passed
// the input register and then the output register. The limits and wrap mode are set over
// the APB port at byte addresses 0, 4 and 8 and should be written only while no
// transaction is in flight.
`include "rotary_encoder_bounded_counter_defines.svh"

module rotary_encoder_bounded_counter
    import reco_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // [1:0] pin_pair, [17:2] load_value
    input  logic [1:0]                s_tuser,   // [1:0] func
    // Result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [23:0]               m_tdata,   // [15:0] count, [17:16] step, [18] load_taken
    // Configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    func_t                  in_func_reg;
    logic [1:0]             in_pins_reg;
    logic [LIMIT_WIDTH-1:0] in_load_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [LIMIT_WIDTH-1:0] out_count_reg;
    step_t                  out_step_reg;
    logic                   out_taken_reg;
    logic [LIMIT_WIDTH-1:0] min_value_reg;
    logic [LIMIT_WIDTH-1:0] max_value_reg;
    logic                   wrap_mode_reg;
    logic                   advance;
    logic                   process;
    logic                   cfg_write;
    logic [1:0]             reg_index;
    decode_t                decode;
    logic [LIMIT_WIDTH-1:0] count;
    logic                   load_taken;
    step_t                  step_out;

    // Pipeline handshake
    assign advance  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= func_t'(s_tuser);
            in_pins_reg <= s_tdata[1:0];
            in_load_reg <= s_tdata[17:2];
        end
    end

    reco_decoder u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_en (process && (in_func_reg == FUNC_SAMPLE)),
        .pin_pair  (in_pins_reg),
        .decode    (decode)
    );

    reco_counter #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counter (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_en      (process),
        .func       (in_func_reg),
        .decode     (decode),
        .load_value (in_load_reg),
        .min_value  (min_value_reg),
        .max_value  (max_value_reg),
        .wrap_mode  (wrap_mode_reg),
        .count      (count),
        .load_taken (load_taken)
    );

    // Step is reported only for sample operations
    assign step_out = (in_func_reg == FUNC_SAMPLE) ? decode.step : STEP_NONE;

    // Output register
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_count_reg <= count;
            out_step_reg  <= step_out;
            out_taken_reg <= load_taken;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_taken_reg, out_step_reg, out_count_reg};

    // Configuration registers
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg <= 16'h8000;
            max_value_reg <= 16'h7FFF;
            wrap_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_MIN_VALUE: min_value_reg <= pwdata[LIMIT_WIDTH-1:0];
                REG_MAX_VALUE: max_value_reg <= pwdata[LIMIT_WIDTH-1:0];
                REG_WRAP_MODE: wrap_mode_reg <= pwdata[0];
                default:       wrap_mode_reg <= wrap_mode_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_index)
            REG_MIN_VALUE:
                prdata = {{(APB_DATA_WIDTH-LIMIT_WIDTH){min_value_reg[LIMIT_WIDTH-1]}},
                          min_value_reg};
            REG_MAX_VALUE:
                prdata = {{(APB_DATA_WIDTH-LIMIT_WIDTH){max_value_reg[LIMIT_WIDTH-1]}},
                          max_value_reg};
            REG_WRAP_MODE:
                prdata = {{(APB_DATA_WIDTH-1){1'b0}}, wrap_mode_reg};
            default:
                prdata = '0;
        endcase
    end

    // Checks
    `RECO_NEVER(a_step_code, m_tvalid && (m_tdata[17:16] == 2'b11), "invalid step code")
    `RECO_NEVER(a_step_load, m_tvalid && out_taken_reg && out_step_reg != STEP_NONE, "mixed flags")
    `RECO_ASSERT(a_stall, in_valid_reg && out_valid_reg && !m_tready |-> !s_tready, "full stall")

endmodule
